[rtl/gap_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gap_pkg;

   localparam int unsigned MAX_ROWS_DEF = 64;
   localparam int unsigned MAX_COLS_DEF = 64;
   localparam int unsigned OCC_W        = 64;
   localparam int unsigned TRK_W        = 7;
   localparam int unsigned KIND_W       = 2;
   localparam int unsigned STS_W        = 2;
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned CSR_DATA_W   = 7;

   localparam logic [KIND_W-1:0] KIND_BEGIN    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXPLICIT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_AUTO     = 2'd2;

   localparam logic [STS_W-1:0] ST_PLACED  = 2'd0;
   localparam logic [STS_W-1:0] ST_SKIPPED = 2'd1;
   localparam logic [STS_W-1:0] ST_OOB     = 2'd2;
   localparam logic [STS_W-1:0] ST_BAD     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MAJOR_AXIS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_COLS = 2'd2;

   typedef struct packed {
      logic             accept;
      logic             clr_start;
      logic             clr_step;
      logic             save;
      logic             restore;
      logic             cand_wrap;
      logic             grow;
      logic             scan_rd;
      logic             scan_next;
      logic             miss_step;
      logic             found;
      logic             mark_start;
      logic             mark_rd;
      logic             mark_wr;
      logic             out_load;
      logic [STS_W-1:0] out_status;
   } gap_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              has_r;
      logic              has_c;
      logic              bad_span;
      logic              rect_oob;
      logic              too_wide;
      logic              over_bound;
      logic              scan_end;
      logic              hit;
      logic              clr_last;
      logic              mark_end;
      logic              out_free;
   } gap_sts_type;

   // columns [col, col+span) of one occupancy row, clipped to the row width
   function automatic logic [OCC_W-1:0] col_mask(input logic [7:0] col, input logic [7:0] span);
      logic [OCC_W-1:0] m;
      m = (span >= 8'(OCC_W)) ? {OCC_W{1'b1}} : ((OCC_W'(1) << span) - OCC_W'(1));
      return (col < 8'(OCC_W)) ? (m << col) : {OCC_W{1'b0}};
   endfunction

endpackage
`default_nettype wire

[rtl/gap_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module gap_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  gap_pkg::gap_sts_type     sts,
   output gap_pkg::gap_cmd_type     cmd
);
   import gap_pkg::*;

   typedef enum logic [11:0] {
      S_CLEAR  = 12'b0000_0000_0001,
      S_IDLE   = 12'b0000_0000_0010,
      S_DECODE = 12'b0000_0000_0100,
      S_CAND   = 12'b0000_0000_1000,
      S_GROW   = 12'b0000_0001_0000,
      S_RD     = 12'b0000_0010_0000,
      S_CHK    = 12'b0000_0100_0000,
      S_FIN    = 12'b0000_1000_0000,
      S_FCHK   = 12'b0001_0000_0000,
      S_MRD    = 12'b0010_0000_0000,
      S_MWR    = 12'b0100_0000_0000,
      S_DONE   = 12'b1000_0000_0000
   } gap_state_type;

   gap_state_type    state_ff, state_in;
   logic             boot_ff, boot_in;
   logic [STS_W-1:0] status_ff, status_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      boot_in   = boot_ff;
      status_in = status_ff;
      cmd.out_status = status_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               if (boot_ff) begin
                  boot_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  status_in = ST_PLACED;
                  state_in  = S_DONE;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.kind == KIND_BEGIN) begin
               cmd.clr_start = 1'b1;
               state_in      = S_CLEAR;
            end else if (sts.kind == KIND_EXPLICIT) begin
               if (!(sts.has_r && sts.has_c)) begin
                  status_in = ST_SKIPPED;
                  state_in  = S_DONE;
               end else if (sts.bad_span) begin
                  status_in = ST_BAD;
                  state_in  = S_DONE;
               end else if (sts.rect_oob) begin
                  status_in = ST_OOB;
                  state_in  = S_DONE;
               end else begin
                  cmd.mark_start = 1'b1;
                  status_in      = ST_PLACED;
                  state_in       = S_MRD;
               end
            end else if (sts.kind == KIND_AUTO) begin
               if (sts.has_r && sts.has_c) begin
                  status_in = ST_SKIPPED;
                  state_in  = S_DONE;
               end else if (sts.bad_span || sts.too_wide) begin
                  status_in = ST_BAD;
                  state_in  = S_DONE;
               end else begin
                  cmd.save = 1'b1;
                  state_in = S_CAND;
               end
            end else begin
               status_in = ST_SKIPPED;
               state_in  = S_DONE;
            end
         end
         S_CAND: begin
            cmd.cand_wrap = 1'b1;
            state_in      = S_GROW;
         end
         S_GROW: begin
            if (sts.over_bound) begin
               cmd.restore = 1'b1;
               status_in   = ST_OOB;
               state_in    = S_DONE;
            end else begin
               cmd.grow = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (sts.scan_end) begin
               state_in = S_FIN;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_CHK;
            end
         end
         S_CHK: begin
            if (sts.hit) begin
               cmd.miss_step = 1'b1;
               state_in      = S_CAND;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_RD;
            end
         end
         S_FIN: begin
            cmd.found = 1'b1;
            state_in  = S_FCHK;
         end
         S_FCHK: begin
            if (sts.rect_oob) begin
               cmd.restore = 1'b1;
               status_in   = ST_OOB;
               state_in    = S_DONE;
            end else begin
               cmd.mark_start = 1'b1;
               status_in      = ST_PLACED;
               state_in       = S_MRD;
            end
         end
         S_MRD: begin
            if (sts.mark_end) begin
               state_in = S_DONE;
            end else begin
               cmd.mark_rd = 1'b1;
               state_in    = S_MWR;
            end
         end
         S_MWR: begin
            cmd.mark_wr = 1'b1;
            state_in    = S_MRD;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         boot_ff   <= 1'b1;
         status_ff <= ST_PLACED;
      end else begin
         state_ff  <= state_in;
         boot_ff   <= boot_in;
         status_ff <= status_in;
      end
   end

   ap_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded over an untaken result");

   ap_accept_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == S_DECODE)
      else $error("accepted request not decoded");

   ap_mark_rmw: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MWR |-> $past(state_ff) == S_MRD)
      else $error("mark write without preceding read");

   ap_grow_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.grow |-> !sts.over_bound)
      else $error("major axis grown past bound");

endmodule
`default_nettype wire

[rtl/gap_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
module gap_dpath #(
   parameter int unsigned MAX_ROWS = gap_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_COLS = gap_pkg::MAX_COLS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [gap_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gap_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [gap_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [gap_pkg::TRK_W-1:0]        req_row_start_line,
   input  wire logic [gap_pkg::TRK_W-1:0]        req_row_end_line,
   input  wire logic [gap_pkg::TRK_W-1:0]        req_col_start_line,
   input  wire logic [gap_pkg::TRK_W-1:0]        req_col_end_line,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [gap_pkg::TRK_W-1:0]             rsp_placed_row_start,
   output logic [gap_pkg::TRK_W-1:0]             rsp_placed_row_end,
   output logic [gap_pkg::TRK_W-1:0]             rsp_placed_col_start,
   output logic [gap_pkg::TRK_W-1:0]             rsp_placed_col_end,
   output logic [gap_pkg::STS_W-1:0]             rsp_status,
   input  gap_pkg::gap_cmd_type                  cmd,
   output gap_pkg::gap_sts_type                  sts
);
   import gap_pkg::*;

   localparam int unsigned MAXB = (MAX_ROWS > 64) ? MAX_ROWS : 64;
   localparam int unsigned AW   = $clog2(MAXB + 256);
   localparam int unsigned RW   = $clog2(MAX_ROWS + 1);
   localparam int unsigned CLW  = $clog2(MAX_COLS + 1);
   localparam int unsigned RAW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic                  axis_ff, axis_in;
   logic [TRK_W-1:0]      init_rows_ff, init_rows_in, init_cols_ff, init_cols_in;
   logic [RW-1:0]         rows_ff, rows_in, sv_rows_ff, sv_rows_in;
   logic [CLW-1:0]        cols_ff, cols_in, sv_cols_ff, sv_cols_in;
   logic [AW-1:0]         maj_ff, maj_in, min_ff, min_in, sv_maj_ff, sv_maj_in, sv_min_ff, sv_min_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic                  has_r_ff, has_r_in, has_c_ff, has_c_in;
   logic [AW-1:0]         rs_ff, rs_in, re_ff, re_in, cs_ff, cs_in, ce_ff, ce_in;
   logic [AW-1:0]         row_ff, row_in, col_ff, col_in, r_ff, r_in;
   logic [OCC_W-1:0]      mask_ff, mask_in, rdata_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TRK_W-1:0]      o_rs_ff, o_rs_in, o_re_ff, o_re_in, o_cs_ff, o_cs_in, o_ce_ff, o_ce_in;
   logic [STS_W-1:0]      o_st_ff, o_st_in;

   logic [AW-1:0]         rows_w, cols_w, sr, sc, smaj, smin, minor_size, major_size, bound;
   logic [AW-1:0]         maj_sum, min_sum, span_c;
   logic                  rowmaj, grow_needed, out_free;

   logic [OCC_W-1:0]      occ_mem [MAX_ROWS];
   logic                  mem_we, mem_re;
   logic [RAW-1:0]        mem_addr;
   logic [OCC_W-1:0]      mem_wdata;

   assign rows_w     = AW'(rows_ff);
   assign cols_w     = AW'(cols_ff);
   assign sr         = has_r_ff ? (re_ff - rs_ff) : AW'(1);
   assign sc         = has_c_ff ? (ce_ff - cs_ff) : AW'(1);
   assign rowmaj     = !axis_ff;
   assign smaj       = rowmaj ? sr : sc;
   assign smin       = rowmaj ? sc : sr;
   assign minor_size = rowmaj ? cols_w : rows_w;
   assign major_size = rowmaj ? rows_w : cols_w;
   assign bound      = rowmaj ? AW'(MAX_ROWS) : AW'(MAX_COLS);
   assign maj_sum    = maj_ff + smaj;
   assign min_sum    = min_ff + smin;
   assign span_c     = ce_ff - cs_ff;
   assign grow_needed = maj_sum > major_size;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign sts.kind       = kind_ff;
   assign sts.has_r      = has_r_ff;
   assign sts.has_c      = has_c_ff;
   assign sts.bad_span   = (has_r_ff && (re_ff <= rs_ff)) || (has_c_ff && (ce_ff <= cs_ff));
   assign sts.rect_oob   = (re_ff > rows_w) || (ce_ff > cols_w);
   assign sts.too_wide   = smin > minor_size;
   assign sts.over_bound = maj_sum > bound;
   assign sts.scan_end   = (r_ff >= row_ff + sr) || (r_ff >= AW'(MAX_ROWS));
   assign sts.hit        = |(rdata_ff & mask_ff);
   assign sts.clr_last   = (r_ff == AW'(MAX_ROWS - 1));
   assign sts.mark_end   = (r_ff >= re_ff) || (r_ff >= AW'(MAX_ROWS));
   assign sts.out_free   = out_free;

   assign mem_we    = cmd.clr_step || cmd.mark_wr;
   assign mem_re    = cmd.scan_rd || cmd.mark_rd;
   assign mem_addr  = r_ff[RAW-1:0];
   assign mem_wdata = cmd.clr_step ? {OCC_W{1'b0}} : (rdata_ff | mask_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         occ_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= occ_mem[mem_addr];
      end
   end

   always_comb begin
      axis_in      = axis_ff;
      init_rows_in = init_rows_ff;
      init_cols_in = init_cols_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      maj_in       = maj_ff;
      min_in       = min_ff;
      sv_rows_in   = sv_rows_ff;
      sv_cols_in   = sv_cols_ff;
      sv_maj_in    = sv_maj_ff;
      sv_min_in    = sv_min_ff;
      kind_in      = kind_ff;
      has_r_in     = has_r_ff;
      has_c_in     = has_c_ff;
      rs_in        = rs_ff;
      re_in        = re_ff;
      cs_in        = cs_ff;
      ce_in        = ce_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      r_in         = r_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff;
      o_rs_in      = o_rs_ff;
      o_re_in      = o_re_ff;
      o_cs_in      = o_cs_ff;
      o_ce_in      = o_ce_ff;
      o_st_in      = o_st_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MAJOR_AXIS:   axis_in      = csr_wdata[0];
            CSR_INITIAL_ROWS: init_rows_in = csr_wdata;
            CSR_INITIAL_COLS: init_cols_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.accept) begin
         kind_in  = req_kind;
         has_r_in = (req_row_start_line != '0);
         has_c_in = (req_col_start_line != '0);
         rs_in    = AW'(req_row_start_line) - AW'(1);
         re_in    = (req_row_end_line != '0) ? (AW'(req_row_end_line) - AW'(1))
                                             : AW'(req_row_start_line);
         cs_in    = AW'(req_col_start_line) - AW'(1);
         ce_in    = (req_col_end_line != '0) ? (AW'(req_col_end_line) - AW'(1))
                                             : AW'(req_col_start_line);
      end

      if (cmd.clr_start) begin
         rows_in = (AW'(init_rows_ff) > AW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(init_rows_ff);
         cols_in = (AW'(init_cols_ff) > AW'(MAX_COLS)) ? CLW'(MAX_COLS) : CLW'(init_cols_ff);
         maj_in  = '0;
         min_in  = '0;
         r_in    = '0;
      end

      if (cmd.clr_step || cmd.scan_next || cmd.mark_wr) begin
         r_in = r_ff + AW'(1);
      end

      if (cmd.save) begin
         sv_rows_in = rows_ff;
         sv_cols_in = cols_ff;
         sv_maj_in  = maj_ff;
         sv_min_in  = min_ff;
      end

      if (cmd.restore) begin
         rows_in = sv_rows_ff;
         cols_in = sv_cols_ff;
         maj_in  = sv_maj_ff;
         min_in  = sv_min_ff;
      end

      if (cmd.cand_wrap && (min_sum > minor_size)) begin
         min_in = '0;
         maj_in = maj_ff + AW'(1);
      end

      if (cmd.grow) begin
         if (grow_needed) begin
            if (rowmaj) begin
               rows_in = RW'(maj_sum);
            end else begin
               cols_in = CLW'(maj_sum);
            end
         end
         row_in  = rowmaj ? maj_ff : min_ff;
         col_in  = rowmaj ? min_ff : maj_ff;
         r_in    = rowmaj ? maj_ff : min_ff;
         mask_in = col_mask((col_in > AW'(255)) ? 8'hFF : col_in[7:0],
                            (sc > AW'(255)) ? 8'hFF : sc[7:0]);
      end

      if (cmd.miss_step) begin
         min_in = min_ff + AW'(1);
      end

      if (cmd.found) begin
         if (min_sum >= minor_size) begin
            min_in = '0;
            maj_in = maj_ff + AW'(1);
         end else begin
            min_in = min_sum;
         end
         if (!has_c_ff) begin
            cs_in = col_ff;
            ce_in = col_ff + sc;
         end
         if (!has_r_ff) begin
            rs_in = row_ff;
            re_in = row_ff + sr;
         end
      end

      if (cmd.mark_start) begin
         r_in    = rs_ff;
         mask_in = col_mask((cs_ff > AW'(255)) ? 8'hFF : cs_ff[7:0],
                            (span_c > AW'(255)) ? 8'hFF : span_c[7:0]);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         o_st_in      = cmd.out_status;
         if (cmd.out_status == ST_PLACED && kind_ff != KIND_BEGIN) begin
            o_rs_in = rs_ff[TRK_W-1:0];
            o_re_in = re_ff[TRK_W-1:0];
            o_cs_in = cs_ff[TRK_W-1:0];
            o_ce_in = ce_ff[TRK_W-1:0];
         end else begin
            o_rs_in = '0;
            o_re_in = '0;
            o_cs_in = '0;
            o_ce_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff      <= 1'b0;
         init_rows_ff <= TRK_W'(1);
         init_cols_ff <= TRK_W'(1);
         rows_ff      <= RW'(1);
         cols_ff      <= CLW'(1);
         maj_ff       <= '0;
         min_ff       <= '0;
         r_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         axis_ff      <= axis_in;
         init_rows_ff <= init_rows_in;
         init_cols_ff <= init_cols_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         maj_ff       <= maj_in;
         min_ff       <= min_in;
         r_ff         <= r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sv_rows_ff <= sv_rows_in;
      sv_cols_ff <= sv_cols_in;
      sv_maj_ff  <= sv_maj_in;
      sv_min_ff  <= sv_min_in;
      kind_ff    <= kind_in;
      has_r_ff   <= has_r_in;
      has_c_ff   <= has_c_in;
      rs_ff      <= rs_in;
      re_ff      <= re_in;
      cs_ff      <= cs_in;
      ce_ff      <= ce_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      mask_ff    <= mask_in;
      o_rs_ff    <= o_rs_in;
      o_re_ff    <= o_re_in;
      o_cs_ff    <= o_cs_in;
      o_ce_ff    <= o_ce_in;
      o_st_ff    <= o_st_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_placed_row_start = o_rs_ff;
   assign rsp_placed_row_end   = o_re_ff;
   assign rsp_placed_col_start = o_cs_ff;
   assign rsp_placed_col_end   = o_ce_ff;
   assign rsp_status           = o_st_ff;

endmodule
`default_nettype wire

[rtl/grid_auto_placer_top.sv]
// Grid auto-placer: places items on a cell grid of up to MAX_ROWS x MAX_COLS.
// Channels: req_* carries one request (kind and four 1-based lines); rsp_*
// returns one result per request (0-based rectangle and status). Both use
// valid/stall; a transfer happens when valid is high and stall is low.
// csr_we/csr_index/csr_wdata write major_axis (0), initial_rows (1) and
// initial_cols (2); sizes take effect at the next begin request.
// The controller sequences each request through the single-port occupancy
// RAM, one row at a time: begin clears every row; an explicit item reads and
// rewrites each row it spans; an auto item scans the rows of each tried
// position, then reads and rewrites each row it spans to mark it. Items
// flagged at decode and auto items flagged during the scan skip the marking.
// One request is in work at a time.
// A finished result sits in an output register; the next request is taken
// while it waits. When the receiver stalls and a second result is ready,
// req_stall stays high until the register drains.
// Reset: config returns to 0/1/1, the grid to 1x1, and a clearing pass
// zeroes every row of the occupancy RAM while req_stall is held high.
`timescale 1ns / 1ps
`default_nettype none
module grid_auto_placer_top #(
   parameter int unsigned MAX_ROWS = gap_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_COLS = gap_pkg::MAX_COLS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [gap_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gap_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [gap_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [gap_pkg::TRK_W-1:0]        req_row_start_line,
   input  wire logic [gap_pkg::TRK_W-1:0]        req_row_end_line,
   input  wire logic [gap_pkg::TRK_W-1:0]        req_col_start_line,
   input  wire logic [gap_pkg::TRK_W-1:0]        req_col_end_line,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [gap_pkg::TRK_W-1:0]             rsp_placed_row_start,
   output logic [gap_pkg::TRK_W-1:0]             rsp_placed_row_end,
   output logic [gap_pkg::TRK_W-1:0]             rsp_placed_col_start,
   output logic [gap_pkg::TRK_W-1:0]             rsp_placed_col_end,
   output logic [gap_pkg::STS_W-1:0]             rsp_status
);
   import gap_pkg::*;

   gap_cmd_type cmd;
   gap_sts_type sts;

   gap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gap_dpath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_kind             (req_kind),
      .req_row_start_line   (req_row_start_line),
      .req_row_end_line     (req_row_end_line),
      .req_col_start_line   (req_col_start_line),
      .req_col_end_line     (req_col_end_line),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_placed_row_start (rsp_placed_row_start),
      .rsp_placed_row_end   (rsp_placed_row_end),
      .rsp_placed_col_start (rsp_placed_col_start),
      .rsp_placed_col_end   (rsp_placed_col_end),
      .rsp_status           (rsp_status),
      .cmd                  (cmd),
      .sts                  (sts)
   );

endmodule
`default_nettype wire

[dv/grid_auto_placer_checker.sv]
`timescale 1ns / 1ps
module grid_auto_placer_checker
   import gap_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [TRK_W-1:0]      req_row_start_line,
   input  logic [TRK_W-1:0]      req_row_end_line,
   input  logic [TRK_W-1:0]      req_col_start_line,
   input  logic [TRK_W-1:0]      req_col_end_line,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [TRK_W-1:0]      rsp_placed_row_start,
   input  logic [TRK_W-1:0]      rsp_placed_row_end,
   input  logic [TRK_W-1:0]      rsp_placed_col_start,
   input  logic [TRK_W-1:0]      rsp_placed_col_end,
   input  logic [STS_W-1:0]      rsp_status,
   output int                    errors,
   output int                    pending
);

   localparam int unsigned GRID_ROWS = MAX_ROWS_DEF;
   localparam int unsigned GRID_COLS = MAX_COLS_DEF;

   typedef struct packed {
      logic [TRK_W-1:0] rs;
      logic [TRK_W-1:0] re;
      logic [TRK_W-1:0] cs;
      logic [TRK_W-1:0] ce;
      logic [STS_W-1:0] st;
   } placement_type;

   placement_type    placement_q[$];
   logic [OCC_W-1:0] occ [0:GRID_ROWS-1];
   int unsigned      cfg_major, cfg_rows, cfg_cols;
   int unsigned      rows_used, cols_used, cur_major, cur_minor;

   assign pending = placement_q.size();

   function automatic logic [OCC_W-1:0] span_mask(int unsigned col, int unsigned span);
      logic [OCC_W-1:0] m;
      m = (span >= 64) ? '1 : ((64'd1 << span) - 64'd1);
      return (col < 64) ? (m << col) : '0;
   endfunction

   function automatic bit area_free(int unsigned row, int unsigned col,
                                    int unsigned nr, int unsigned nc);
      logic [OCC_W-1:0] m;
      m = span_mask(col, nc);
      for (int unsigned r = row; r < row + nr && r < GRID_ROWS; r++)
         if ((occ[r] & m) != 0) return 0;
      return 1;
   endfunction

   function automatic void occupy(int unsigned r0, int unsigned r1,
                                  int unsigned c0, int unsigned c1);
      logic [OCC_W-1:0] m;
      m = span_mask(c0, c1 - c0);
      for (int unsigned r = r0; r < r1 && r < GRID_ROWS; r++) occ[r] |= m;
   endfunction

   function automatic void clear_grid();
      foreach (occ[i]) occ[i] = '0;
      rows_used = (cfg_rows > GRID_ROWS) ? GRID_ROWS : cfg_rows;
      cols_used = (cfg_cols > GRID_COLS) ? GRID_COLS : cfg_cols;
      cur_major = 0;
      cur_minor = 0;
   endfunction

   function automatic placement_type result(int unsigned rs, int unsigned re, int unsigned cs,
                                            int unsigned ce, logic [STS_W-1:0] st);
      placement_type p;
      if (st != ST_PLACED) begin
         rs = 0; re = 0; cs = 0; ce = 0;
      end
      p.rs = rs[TRK_W-1:0];
      p.re = re[TRK_W-1:0];
      p.cs = cs[TRK_W-1:0];
      p.ce = ce[TRK_W-1:0];
      p.st = st;
      return p;
   endfunction

   function automatic placement_type place_item(logic [KIND_W-1:0] kind,
                                                logic [TRK_W-1:0] rsl, logic [TRK_W-1:0] rel,
                                                logic [TRK_W-1:0] csl, logic [TRK_W-1:0] cel);
      bit          has_r, has_c, rowmaj;
      int unsigned rs, re, cs, ce, sr, sc, smaj, smin, minor_size, bound, major_size;
      int unsigned sv_rows, sv_cols, sv_maj, sv_min, row, col;
      has_r = rsl != 0;
      has_c = csl != 0;
      rs = 0; re = 0; cs = 0; ce = 0; row = 0; col = 0;
      if (kind == KIND_BEGIN) begin
         clear_grid();
         return result(0, 0, 0, 0, ST_PLACED);
      end
      if (kind != KIND_EXPLICIT && kind != KIND_AUTO) return result(0, 0, 0, 0, ST_SKIPPED);
      if (has_r) begin
         rs = rsl - 1;
         re = (rel != 0) ? rel - 1 : rs + 1;
      end
      if (has_c) begin
         cs = csl - 1;
         ce = (cel != 0) ? cel - 1 : cs + 1;
      end
      if (kind == KIND_EXPLICIT) begin
         if (!(has_r && has_c)) return result(0, 0, 0, 0, ST_SKIPPED);
         if (re <= rs || ce <= cs) return result(0, 0, 0, 0, ST_BAD);
         if (re > rows_used || ce > cols_used) return result(0, 0, 0, 0, ST_OOB);
         occupy(rs, re, cs, ce);
         return result(rs, re, cs, ce, ST_PLACED);
      end
      if (has_r && has_c) return result(0, 0, 0, 0, ST_SKIPPED);
      if ((has_r && re <= rs) || (has_c && ce <= cs)) return result(0, 0, 0, 0, ST_BAD);
      sr = has_r ? re - rs : 1;
      sc = has_c ? ce - cs : 1;
      rowmaj = cfg_major == 0;
      smaj = rowmaj ? sr : sc;
      smin = rowmaj ? sc : sr;
      minor_size = rowmaj ? cols_used : rows_used;
      bound = rowmaj ? GRID_ROWS : GRID_COLS;
      sv_rows = rows_used; sv_cols = cols_used; sv_maj = cur_major; sv_min = cur_minor;
      if (smin > minor_size) return result(0, 0, 0, 0, ST_BAD);
      forever begin
         if (cur_minor + smin > minor_size) begin
            cur_minor = 0;
            cur_major++;
         end
         major_size = rowmaj ? rows_used : cols_used;
         if (cur_major + smaj > major_size) begin
            if (cur_major + smaj > bound) begin
               cur_major = sv_maj; cur_minor = sv_min;
               rows_used = sv_rows; cols_used = sv_cols;
               return result(0, 0, 0, 0, ST_OOB);
            end
            if (rowmaj) rows_used = cur_major + smaj;
            else cols_used = cur_major + smaj;
         end
         row = rowmaj ? cur_major : cur_minor;
         col = rowmaj ? cur_minor : cur_major;
         if (area_free(row, col, sr, sc)) begin
            cur_minor += smin;
            if (cur_minor >= minor_size) begin
               cur_minor = 0;
               cur_major++;
            end
            break;
         end
         cur_minor++;
      end
      if (!has_c) begin cs = col; ce = col + sc; end
      if (!has_r) begin rs = row; re = row + sr; end
      if (re > rows_used || ce > cols_used) begin
         cur_major = sv_maj; cur_minor = sv_min;
         rows_used = sv_rows; cols_used = sv_cols;
         return result(0, 0, 0, 0, ST_OOB);
      end
      occupy(rs, re, cs, ce);
      return result(rs, re, cs, ce, ST_PLACED);
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      placement_type want;
      if (reset) begin
         placement_q.delete();
         cfg_major = 0; cfg_rows = 1; cfg_cols = 1;
         clear_grid();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (placement_q.size() == 0) begin
               report_mismatch("unrequested result", 1, 0);
            end else begin
               want = placement_q.pop_front();
               if (rsp_placed_row_start != want.rs)
                  report_mismatch("placed_row_start", rsp_placed_row_start, want.rs);
               if (rsp_placed_row_end != want.re)
                  report_mismatch("placed_row_end", rsp_placed_row_end, want.re);
               if (rsp_placed_col_start != want.cs)
                  report_mismatch("placed_col_start", rsp_placed_col_start, want.cs);
               if (rsp_placed_col_end != want.ce)
                  report_mismatch("placed_col_end", rsp_placed_col_end, want.ce);
               if (rsp_status != want.st)
                  report_mismatch("status", rsp_status, want.st);
            end
         end
         if (req_valid && !req_stall)
            placement_q.insert(placement_q.size(),
                               place_item(req_kind, req_row_start_line, req_row_end_line,
                                          req_col_start_line, req_col_end_line));
         if (csr_we) begin
            case (csr_index)
               CSR_MAJOR_AXIS:   cfg_major = csr_wdata[0];
               CSR_INITIAL_ROWS: cfg_rows = csr_wdata;
               CSR_INITIAL_COLS: cfg_cols = csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

[dv/tb_grid_auto_placer_top.sv]
`timescale 1ns / 1ps
module tb_grid_auto_placer_top;
   import gap_pkg::*;

   localparam int STALL_LIMIT = 2000000;
   localparam int ITEM_TARGET = 1350;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  csr_we = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 0;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [TRK_W-1:0]      req_row_start_line = '0;
   logic [TRK_W-1:0]      req_row_end_line = '0;
   logic [TRK_W-1:0]      req_col_start_line = '0;
   logic [TRK_W-1:0]      req_col_end_line = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   logic [TRK_W-1:0]      rsp_placed_row_start, rsp_placed_row_end;
   logic [TRK_W-1:0]      rsp_placed_col_start, rsp_placed_col_end;
   logic [STS_W-1:0]      rsp_status;
   int                    errors, pending;
   bit                    quiet = 0;
   int                    sent = 0;
   int                    idle_cycles = 0;
   int                    stall_left = 0;

   grid_auto_placer_top DUT (.*);
   grid_auto_placer_checker u_checker (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (quiet) stall_left = 0;
      else if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
      rsp_stall = stall_left > 0;
   end

   task automatic send_request(logic [KIND_W-1:0] k, logic [TRK_W-1:0] rsl,
                               logic [TRK_W-1:0] rel, logic [TRK_W-1:0] csl,
                               logic [TRK_W-1:0] cel);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_kind = k;
      req_row_start_line = rsl;
      req_row_end_line = rel;
      req_col_start_line = csl;
      req_col_end_line = cel;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 0;
      sent++;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_layout(int unsigned major, int unsigned rows, int unsigned cols);
      drain();
      write_csr(CSR_MAJOR_AXIS, major);
      write_csr(CSR_INITIAL_ROWS, rows);
      write_csr(CSR_INITIAL_COLS, cols);
      send_request(KIND_BEGIN, 0, 0, 0, 0);
   endtask

   function automatic int unsigned pick_size();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return 64;
      if (r == 2) return $urandom_range(65, 127);
      if (r == 3) return $urandom_range(9, 63);
      return $urandom_range(1, 8);
   endfunction

   function automatic logic [TRK_W-1:0] start_line(int unsigned n);
      int unsigned hi;
      if ($urandom_range(0, 19) == 0) return TRK_W'($urandom_range(0, 127));
      hi = (n == 0) ? 1 : ((n > 64) ? 65 : n + 1);
      return TRK_W'($urandom_range(1, hi));
   endfunction

   function automatic logic [TRK_W-1:0] end_line(logic [TRK_W-1:0] s);
      int unsigned r, e;
      r = $urandom_range(0, 9);
      if (r < 4) return '0;
      if (r < 8) begin
         e = s + $urandom_range(1, 3);
         return (e > 127) ? 7'd127 : e[TRK_W-1:0];
      end
      if (r == 8) return TRK_W'($urandom_range(0, s));
      return TRK_W'($urandom_range(0, 127));
   endfunction

   initial begin
      logic [TRK_W-1:0] rs, cs;
      int unsigned      rows, cols, n_exp, n_auto, mode;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed
      send_request(KIND_AUTO, 0, 0, 0, 0);
      send_request(KIND_AUTO, 0, 0, 0, 0);
      set_layout(0, 2, 2);
      send_request(KIND_EXPLICIT, 1, 0, 1, 0);
      send_request(KIND_EXPLICIT, 1, 0, 0, 0);
      send_request(KIND_EXPLICIT, 2, 2, 1, 0);
      send_request(KIND_EXPLICIT, 3, 0, 1, 0);
      send_request(KIND_AUTO, 1, 0, 1, 0);
      send_request(KIND_AUTO, 0, 0, 0, 4);
      send_request(KIND_AUTO, 0, 0, 1, 4);
      send_request(KIND_AUTO, 0, 0, 0, 0);
      send_request(KIND_AUTO, 2, 0, 0, 0);
      send_request(2'd3, 7'h7f, 7'h7f, 7'h7f, 7'h7f);
      set_layout(1, 64, 64);
      send_request(KIND_EXPLICIT, 1, 65, 1, 65);
      send_request(KIND_EXPLICIT, 64, 65, 64, 65);
      send_request(KIND_EXPLICIT, 127, 0, 127, 0);
      send_request(KIND_AUTO, 0, 0, 0, 0);
      set_layout(0, 127, 0);
      send_request(KIND_AUTO, 0, 0, 0, 0);
      send_request(KIND_AUTO, 0, 0, 1, 0);
      set_layout(1, 0, 127);
      send_request(KIND_AUTO, 0, 0, 0, 0);
      send_request(KIND_AUTO, 0, 66, 0, 0);

      // random layouts
      while (sent < ITEM_TARGET) begin
         if (sent > ITEM_TARGET - 150) quiet = 1;
         rows = pick_size();
         cols = pick_size();
         set_layout($urandom_range(0, 1), rows, cols);
         n_exp = $urandom_range(0, 12);
         n_auto = $urandom_range(5, 30);
         for (int i = 0; i < n_exp + n_auto; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_request(KIND_W'($urandom_range(0, 3)), TRK_W'($urandom_range(0, 127)),
                            TRK_W'($urandom_range(0, 127)), TRK_W'($urandom_range(0, 127)),
                            TRK_W'($urandom_range(0, 127)));
            end else if (i < n_exp) begin
               rs = start_line(rows);
               cs = start_line(cols);
               send_request(KIND_EXPLICIT, rs, end_line(rs), cs, end_line(cs));
            end else begin
               mode = $urandom_range(0, 3);
               rs = (mode == 1) ? start_line(rows) : 7'd0;
               cs = (mode == 2) ? start_line(cols) : 7'd0;
               send_request(KIND_AUTO, rs, (mode == 3) ? end_line(0) : end_line(rs),
                            cs, (mode == 3) ? end_line(0) : end_line(cs));
            end
         end
      end

      quiet = 1;
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[files.f]
rtl/gap_pkg.sv
rtl/gap_ctrl.sv
rtl/gap_dpath.sv
rtl/grid_auto_placer_top.sv
dv/grid_auto_placer_checker.sv
dv/tb_grid_auto_placer_top.sv
